// ===== hw/rtl/pbb_pkg.sv =====
`timescale 1ns / 1ps
package pbb_pkg;
  localparam int FracBits = 16;
  localparam int WordW = 32;
  localparam int SizeW = 14;
  localparam int NumW = WordW + 2;
  localparam int DivNW = NumW + SizeW + FracBits;
  localparam int DivDW = WordW + 2;
  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam longint EpsVal = ((64'd1 << FracBits) + 64'd50000) / 64'd100000;
  localparam logic signed [WordW-1:0] Eps = WordW'(EpsVal);

  typedef enum logic [1:0] {
    FUNC_LOAD_MV = 2'd0,
    FUNC_LOAD_PJ = 2'd1,
    FUNC_PROJECT = 2'd2
  } func_t;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic group_start;
    logic group_end;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic visible;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;
    logic any_visible;
    logic box_ok;
    logic group_last;
  } out_req_t;
endpackage

// ===== hw/rtl/projected_box_bounds.sv =====
`timescale 1ns / 1ps
// Projects model-space points through modelview and projection matrices and
// tracks their screen bounding box. Matrix load requests and ignored requests
// are handled in the idle state without leaving it. A project request runs 24
// products through one shared 32x32 multiplier, each in two steps (operand
// fetch, then accumulate). It then runs two 64-step restoring divisions in one
// shared divider, one quotient bit a cycle. Each division has a setup state
// before it and a store step after it. When the point is behind the camera no
// division runs. The next request is taken in the cycle after the result is
// taken, and receiver stalls delay it. The block takes no new request until
// the result is taken.
module projected_box_bounds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbb_pkg::in_req_t    in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output pbb_pkg::out_req_t   out_req,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [13:0]         cfg_data
);
  import pbb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_DSET = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_BOX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SizeW-1:0] width_r, height_r;
  logic signed [WordW-1:0] mv_mem [16];
  logic signed [WordW-1:0] pj_mem [16];
  logic signed [WordW-1:0] mv_q_r, mv_b_r, pj_q_r;
  in_req_t req_r;
  logic [4:0] step_r;
  logic signed [WordW+2:0] acc_r;
  logic signed [WordW-1:0] v_r [4];
  logic signed [WordW-1:0] cx_r, cy_r, cw_r;
  logic signed [WordW-1:0] sx_r, sy_r;
  logic signed [WordW-1:0] bminx_r, bmaxx_r, bminy_r, bmaxy_r;
  logic seen_r, vis_r, axis_r;
  logic [DivNW-1:0] dnum_r;
  logic [DivDW:0] drem_r;
  logic [DivDW-1:0] dden_r;
  logic [6:0] dcnt_r;
  logic dover_r, dneg_r;
  logic [63:0] dq_r;

  // step 0..11: modelview rows (3 products each), 12..23: projection rows 0,1,3
  logic [1:0] row, col;
  logic [3:0] mv_addr, pj_addr;
  logic signed [WordW-1:0] opb;
  always_comb begin
    if (step_r >= 5'd12) begin
      row = 2'((step_r - 5'd12) >> 2);
      col = step_r[1:0];
      if (row == 2'd2) row = 2'd3;
    end else begin
      if (step_r >= 5'd9) row = 2'd3;
      else if (step_r >= 5'd6) row = 2'd2;
      else if (step_r >= 5'd3) row = 2'd1;
      else row = 2'd0;
      col = 2'(step_r - 5'd3 * {3'd0, row});
    end
    mv_addr = {col, row};
    pj_addr = {col, row};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_req.func == FUNC_LOAD_MV)
      mv_mem[in_req.word_index] <= in_req.word_value;
    if (state_r == S_IDLE && in_valid && in_req.func == FUNC_LOAD_PJ)
      pj_mem[in_req.word_index] <= in_req.word_value;
    mv_q_r <= mv_mem[mv_addr];
    mv_b_r <= mv_mem[{2'd3, row}];
    pj_q_r <= pj_mem[pj_addr];
  end

  always_comb begin
    if (step_r < 5'd12) begin
      case (col)
        2'd0: opb = req_r.point_x;
        2'd1: opb = req_r.point_y;
        default: opb = req_r.point_z;
      endcase
    end else begin
      opb = v_r[col];
    end
  end

  // shared multiplier
  logic signed [WordW-1:0] opa;
  logic signed [2*WordW-1:0] prod;
  logic [2*WordW-1:0] pmag;
  logic [2*WordW-FracBits-1:0] ptr;
  logic signed [WordW-1:0] pfx;
  logic pneg;
  logic signed [WordW+2:0] acc_sum, acc_init;
  logic signed [WordW-1:0] acc_sat;
  assign opa = (step_r < 5'd12) ? mv_q_r : pj_q_r;
  always_comb begin
    prod = opa * opb;
    pneg = prod[2*WordW-1];
    pmag = pneg ? -prod : prod;
    ptr = pmag[2*WordW-1:FracBits];
    if (pneg)
      pfx = (ptr > (2*WordW-FracBits)'(64'h80000000)) ? WordMin : -WordW'(ptr);
    else
      pfx = (ptr > (2*WordW-FracBits)'(64'h7FFFFFFF)) ? WordMax : WordW'(ptr);
    acc_init = (step_r < 5'd12) ? (WordW+3)'(signed'(mv_b_r)) : '0;
    acc_sum = (col == 2'd0) ? (WordW+3)'(pfx) + acc_init
            : (WordW+3)'(pfx) + acc_r;
    if (acc_sum > (WordW+3)'(WordMax)) acc_sat = WordMax;
    else if (acc_sum < (WordW+3)'(WordMin)) acc_sat = WordMin;
    else acc_sat = WordW'(acc_sum);
  end
  logic row_last;
  assign row_last = (step_r < 5'd12) ? (col == 2'd2) : (col == 2'd3);

  // divider setup
  logic signed [NumW-1:0] num;
  logic [NumW-1:0] nmag;
  logic [SizeW-1:0] size;
  always_comb begin
    if (!axis_r) begin
      num = NumW'(cx_r) + NumW'(cw_r);
      size = width_r;
    end else begin
      num = NumW'(cw_r) - NumW'(cy_r);
      size = height_r;
    end
    nmag = num[NumW-1] ? -num : num;
  end
  logic [DivDW:0] rsh;
  assign rsh = {drem_r[DivDW-1:0], dnum_r[DivNW-1]};
  logic signed [WordW-1:0] qres;
  always_comb begin
    if (dneg_r)
      qres = (dover_r || dq_r > 64'h7FFFFFFF) ? WordMin : -WordW'(dq_r);
    else
      qres = (dover_r || dq_r > 64'h7FFFFFFF) ? WordMax : WordW'(dq_r);
  end

  logic signed [WordW:0] bw, bh;
  assign bw = (WordW+1)'(bmaxx_r) - (WordW+1)'(bminx_r);
  assign bh = (WordW+1)'(bmaxy_r) - (WordW+1)'(bminy_r);

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && in_req.func == FUNC_PROJECT) state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: state_nxt = (step_r == 5'd23) ? S_DSET : S_MUL;
      S_DSET: state_nxt = (cw_r > Eps) ? S_DIV : S_BOX;
      S_DIV: if (dcnt_r == 7'd0) state_nxt = axis_r ? S_BOX : S_DSET;
      S_BOX: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= SizeW'(1920);
      height_r <= SizeW'(1080);
      bminx_r <= WordMax;
      bminy_r <= WordMax;
      bmaxx_r <= WordMin;
      bmaxy_r <= WordMin;
      seen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          axis_r <= 1'b0;
          if (in_valid && in_req.func == FUNC_PROJECT) begin
            req_r <= in_req;
            if (in_req.group_start) begin
              bminx_r <= WordMax;
              bminy_r <= WordMax;
              bmaxx_r <= WordMin;
              bmaxy_r <= WordMin;
              seen_r <= 1'b0;
            end
          end
        end
        S_ACC: begin
          acc_r <= acc_sum;
          step_r <= step_r + 5'd1;
          if (row_last) begin
            if (step_r < 5'd12) v_r[row] <= acc_sat;
            else if (row == 2'd0) cx_r <= acc_sat;
            else if (row == 2'd1) cy_r <= acc_sat;
            else cw_r <= acc_sat;
          end
        end
        S_DSET: begin
          vis_r <= cw_r > Eps;
          dnum_r <= DivNW'(nmag) * DivNW'({size, {FracBits{1'b0}}});
          dden_r <= DivDW'({cw_r, 1'b0});
          drem_r <= '0;
          dq_r <= '0;
          dover_r <= 1'b0;
          dneg_r <= num[NumW-1];
          dcnt_r <= 7'(DivNW);
          if (!(cw_r > Eps)) begin
            sx_r <= '0;
            sy_r <= '0;
          end
        end
        S_DIV: begin
          if (dcnt_r != 7'd0) begin
            dnum_r <= dnum_r << 1;
            dcnt_r <= dcnt_r - 7'd1;
            if (rsh >= {1'b0, dden_r}) begin
              drem_r <= rsh - {1'b0, dden_r};
              if (dcnt_r > 7'd64) dover_r <= 1'b1;
              else dq_r[6'(dcnt_r - 7'd1)] <= 1'b1;
            end else begin
              drem_r <= rsh;
            end
          end else begin
            if (!axis_r) sx_r <= qres;
            else sy_r <= qres;
            axis_r <= 1'b1;
          end
        end
        S_BOX: if (vis_r) begin
          seen_r <= 1'b1;
          if (sx_r < bminx_r) bminx_r <= sx_r;
          if (sx_r > bmaxx_r) bmaxx_r <= sx_r;
          if (sy_r < bminy_r) bminy_r <= sy_r;
          if (sy_r > bmaxy_r) bmaxy_r <= sy_r;
        end
        default: ;
      endcase
    end
  end

  logic one_ok;
  assign one_ok = bw >= (WordW+1)'(1 << FracBits) && bh >= (WordW+1)'(1 << FracBits)
    && bw <= (WordW+1)'({width_r, {FracBits{1'b0}}})
    && bh <= (WordW+1)'({height_r, {FracBits{1'b0}}});

  always_comb begin
    out_req.screen_x = sx_r;
    out_req.screen_y = sy_r;
    out_req.visible = vis_r;
    out_req.box_min_x = bminx_r;
    out_req.box_max_x = bmaxx_r;
    out_req.box_min_y = bminy_r;
    out_req.box_max_y = bmaxy_r;
    out_req.any_visible = seen_r;
    out_req.box_ok = seen_r && one_ok;
    out_req.group_last = req_r.group_end;
  end
endmodule

// ===== verif/projected_box_bounds_tb.sv =====
`timescale 1ns / 1ps
module projected_box_bounds_tb;
  import pbb_pkg::*;

  localparam logic [1:0] FuncNone = 2'd3;
  localparam longint One = 64'sd65536;
  localparam longint FieldMax = 64'sd2147483647;
  localparam longint FieldMin = -64'sd2147483648;
  localparam int Limit = 3000000;
  localparam int Drain = 120;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_req_t in_req;
  out_req_t out_req;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [13:0] cfg_data;

  projected_box_bounds DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_req_t pending_q[$];
  out_req_t expected_q[$];
  int send_idle, recv_idle;
  int fails;
  int cycles;

  longint mv_words[16];
  longint pj_words[16];
  longint min_x, max_x, min_y, max_y;
  bit seen_vis;
  longint scr_w, scr_h;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    return v > FieldMax ? FieldMax : (v < FieldMin ? FieldMin : v);
  endfunction

  function automatic longint fx_product(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p / One);
  endfunction

  function automatic longint to_pixels(longint num, longint cw, longint size);
    logic [127:0] n, d, q;
    longint mag;
    mag = num < 0 ? -num : num;
    n = 128'(mag) * 128'(size);
    n = n << 16;
    d = 128'(2 * cw);
    q = n / d;
    if (q > 128'(FieldMax)) return num >= 0 ? FieldMax : FieldMin;
    return num >= 0 ? longint'(q) : -longint'(q);
  endfunction

  task automatic clear_bounds();
    min_x = FieldMax;
    max_x = FieldMin;
    min_y = FieldMax;
    max_y = FieldMin;
    seen_vis = 1'b0;
  endtask

  task automatic project_point(input in_req_t r);
    longint p[3], v[4], acc, cx, cy, cw, sx, sy, bw, bh;
    bit vis, ok;
    out_req_t o;
    cx = 0; cy = 0; cw = 0; sx = 0; sy = 0; ok = 0;
    if (r.func == FUNC_LOAD_MV) begin
      mv_words[r.word_index] = longint'(r.word_value);
      return;
    end
    if (r.func == FUNC_LOAD_PJ) begin
      pj_words[r.word_index] = longint'(r.word_value);
      return;
    end
    if (r.func != FUNC_PROJECT) return;
    if (r.group_start) clear_bounds();
    p[0] = longint'(r.point_x);
    p[1] = longint'(r.point_y);
    p[2] = longint'(r.point_z);
    for (int i = 0; i < 4; i++) begin
      acc = mv_words[12 + i];
      for (int k = 0; k < 3; k++) acc += fx_product(mv_words[i + 4 * k], p[k]);
      v[i] = sat32(acc);
    end
    for (int i = 0; i < 4; i++) begin
      if (i == 2) continue;
      acc = 0;
      for (int k = 0; k < 4; k++) acc += fx_product(pj_words[i + 4 * k], v[k]);
      acc = sat32(acc);
      if (i == 0) cx = acc;
      else if (i == 1) cy = acc;
      else cw = acc;
    end
    vis = cw > longint'(Eps);
    if (vis) begin
      sx = to_pixels(cx + cw, cw, scr_w);
      sy = to_pixels(cw - cy, cw, scr_h);
      seen_vis = 1'b1;
      if (sx < min_x) min_x = sx;
      if (sx > max_x) max_x = sx;
      if (sy < min_y) min_y = sy;
      if (sy > max_y) max_y = sy;
    end
    if (seen_vis) begin
      bw = max_x - min_x;
      bh = max_y - min_y;
      ok = bw >= One && bh >= One && bw <= (scr_w << 16) && bh <= (scr_h << 16);
    end
    o.screen_x = sx[31:0];
    o.screen_y = sy[31:0];
    o.visible = vis;
    o.box_min_x = min_x[31:0];
    o.box_max_x = max_x[31:0];
    o.box_min_y = min_y[31:0];
    o.box_max_y = max_y[31:0];
    o.any_visible = seen_vis;
    o.box_ok = ok;
    o.group_last = r.group_end;
    expected_q.push_back(o);
  endtask

  task automatic report(input string field, input longint got, input longint want);
    if (got != want) begin
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
      fails++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) project_point(in_req);
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_req <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_req_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected request", 1, 0);
        end else begin
          w = expected_q.pop_front();
          report("screen_x", out_req.screen_x, w.screen_x);
          report("screen_y", out_req.screen_y, w.screen_y);
          report("visible", out_req.visible, w.visible);
          report("box_min_x", out_req.box_min_x, w.box_min_x);
          report("box_max_x", out_req.box_max_x, w.box_max_x);
          report("box_min_y", out_req.box_min_y, w.box_min_y);
          report("box_max_y", out_req.box_max_y, w.box_max_y);
          report("any_visible", out_req.any_visible, w.any_visible);
          report("box_ok", out_req.box_ok, w.box_ok);
          report("group_last", out_req.group_last, w.group_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("projected_box_bounds test failed");
      $finish;
    end
  end

  task automatic add_load(input logic [1:0] f, input int idx, input logic [31:0] val);
    in_req_t r;
    r.func = f;
    r.word_index = idx[3:0];
    r.word_value = val;
    r.point_x = $urandom;
    r.point_y = $urandom;
    r.point_z = $urandom;
    r.group_start = 1'($urandom_range(1));
    r.group_end = 1'($urandom_range(1));
    pending_q.push_back(r);
  endtask

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input bit gs, input bit ge);
    in_req_t r;
    r.func = FUNC_PROJECT;
    r.word_index = 4'($urandom);
    r.word_value = $urandom;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    r.group_start = gs;
    r.group_end = ge;
    pending_q.push_back(r);
  endtask

  task automatic load_camera();
    for (int i = 0; i < 16; i++)
      add_load(FUNC_LOAD_MV, i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    for (int i = 0; i < 16; i++)
      add_load(FUNC_LOAD_PJ, i, (i == 0 || i == 5) ? 32'h0001_0000 :
                                (i == 11) ? 32'hFFFF_0000 : 32'h0);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_WIDTH) scr_w = val;
    else scr_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_groups(input int count);
    int n, sz;
    logic [31:0] z;
    n = 0;
    while (n < count) begin
      sz = $urandom_range(100);
      if (sz < 4) begin
        load_camera();
        n += 32;
      end else if (sz < 12) begin
        add_load(2'($urandom_range(1)), $urandom_range(15),
                 $urandom_range(1) ? $urandom : 32'($urandom_range(131072)) - 32'h10000);
        n++;
      end else if (sz < 15) begin
        add_load(FuncNone, $urandom_range(15), $urandom);
        n++;
      end else if (sz < 22) begin
        add_point($urandom, $urandom, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        n++;
      end else begin
        sz = $urandom_range(1, 8);
        for (int i = 0; i < sz; i++) begin
          z = $urandom_range(9) == 0 ? $urandom : -32'($urandom_range(100 << 16, 1));
          add_point(32'($urandom_range(400 << 16)) - 32'(200 << 16),
                    32'($urandom_range(400 << 16)) - 32'(200 << 16),
                    z, i == 0, i == sz - 1);
          n++;
        end
      end
    end
  endtask

  initial begin
    logic [13:0] widths[5];
    logic [13:0] heights[5];
    widths = '{14'd1920, 14'd1, 14'd8192, 14'd0, 14'd16383};
    heights = '{14'd1080, 14'd8192, 14'd1, 14'd16383, 14'd480};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 12;
    recv_idle = 61;
    fails = 0;
    cycles = 0;
    clear_bounds();
    scr_w = 1920;
    scr_h = 1080;
    foreach (mv_words[i]) begin
      mv_words[i] = 0;
      pj_words[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle = 61;
        recv_idle = 12;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_WIDTH, widths[ph]);
      write_reg(CFG_HEIGHT, heights[ph]);
      if (ph == 0) begin
        load_camera();
        add_point(32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0, 1'b1);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1, 1'b1);
        add_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
        add_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFE, 1'b0, 1'b0);
        add_point(32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
        add_load(FuncNone, 15, 32'hFFFF_FFFF);
        add_load(FUNC_LOAD_MV, 12, 32'h7FFF_FFFF);
        add_load(FUNC_LOAD_MV, 12, 32'h0);
      end
      random_groups(310);
      wait_idle();
    end
    if (fails == 0)
      $display("projected_box_bounds test passed");
    else
      $display("projected_box_bounds test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/pbb_pkg.sv
hw/rtl/projected_box_bounds.sv
verif/projected_box_bounds_tb.sv
